// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// prop must hold at every clock edge outside reset
`define TVBS_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("serializer assertion failed");

// prop must never hold outside reset
`define TVBS_ASSERT_NEVER(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error("serializer forbidden condition seen");

`endif

// ===== rtl/tvbs_pkg.sv =====
// ----------------------------------------------------------------------------
// tvbs_pkg
// Types, constants and encode functions of the typed value byte serializer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tvbs_pkg;

  localparam int unsigned FormatW    = 3;
  localparam int unsigned ValueW     = 64;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned MaxBytes   = 10;
  localparam int unsigned CountW     = 4;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [FormatW-1:0] {
    FmtByte    = 3'd0,
    FmtFixed32 = 3'd1,
    FmtFixed64 = 3'd2,
    FmtComp32  = 3'd3,
    FmtComp64  = 3'd4
  } tvbs_fmt_e;

  // compact form range limits
  localparam logic signed [31:0] OneMin   = -32'sd64;
  localparam logic signed [31:0] OneMax   = 32'sd127;
  localparam logic signed [31:0] TwoMin   = -32'sh400;
  localparam logic signed [31:0] TwoMax   = 32'sh3ff;
  localparam logic signed [31:0] ThreeMin = -32'sh40000;
  localparam logic signed [31:0] ThreeMax = 32'sh3ffff;
  localparam logic signed [31:0] FourMin  = -32'sh4000000;
  localparam logic signed [31:0] FourMax  = 32'sh3ffffff;

  localparam logic [7:0] PfxTwo   = 8'h80;
  localparam logic [7:0] PfxThree = 8'h90;
  localparam logic [7:0] PfxFour  = 8'ha0;
  localparam logic [7:0] PfxFive  = 8'hb0;

  // byte 0 is sent first
  typedef struct packed {
    logic [MaxBytes-1:0][ByteW-1:0] bytes;
    logic [CountW-1:0]              count;
  } tvbs_desc_t;

  typedef struct packed {
    logic [4:0][ByteW-1:0] b;
    logic [2:0]            n;
  } tvbs_c32_t;

  function automatic logic [3:0][ByteW-1:0] fixed32(logic [31:0] u);
    return {u[7:0], u[15:8], u[23:16], u[31:24]};
  endfunction

  function automatic tvbs_c32_t comp32(logic [31:0] u);
    tvbs_c32_t         r;
    logic signed [31:0] v;
    v = signed'(u);
    r.b = '0;
    if (v >= OneMin && v <= OneMax) begin
      r.n    = 3'd1;
      r.b[0] = u[7:0];
    end else if (v >= TwoMin && v <= TwoMax) begin
      r.n    = 3'd2;
      r.b[0] = PfxTwo | {4'h0, u[11:8]};
      r.b[1] = u[7:0];
    end else if (v >= ThreeMin && v <= ThreeMax) begin
      r.n    = 3'd3;
      r.b[0] = PfxThree | {4'h0, u[19:16]};
      r.b[1] = u[15:8];
      r.b[2] = u[7:0];
    end else if (v >= FourMin && v <= FourMax) begin
      r.n    = 3'd4;
      r.b[0] = PfxFour | {4'h0, u[27:24]};
      r.b[1] = u[23:16];
      r.b[2] = u[15:8];
      r.b[3] = u[7:0];
    end else begin
      r.n      = 3'd5;
      r.b[0]   = PfxFive;
      r.b[4:1] = fixed32(u);
    end
    return r;
  endfunction

endpackage

// ===== rtl/tvbs_in_if.sv =====
// ----------------------------------------------------------------------------
// tvbs_in_if
// Input item channel: format code and raw value bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tvbs_in_if;
  logic                           valid;
  logic                           ready;
  logic [tvbs_pkg::FormatW-1:0]   format;
  logic [tvbs_pkg::ValueW-1:0]    value;

  modport source (output valid, format, value, input ready);
  modport sink   (input valid, format, value, output ready);
endinterface

// ===== rtl/tvbs_out_if.sv =====
// ----------------------------------------------------------------------------
// tvbs_out_if
// Output byte channel: one serialized byte and its last marker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tvbs_out_if;
  logic                        valid;
  logic                        ready;
  logic [tvbs_pkg::ByteW-1:0]  out_byte;
  logic                        last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

// ===== rtl/tvbs_front.sv =====
// ----------------------------------------------------------------------------
// tvbs_front
// Accepts input items, classifies the format and builds the byte descriptor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tvbs_front (
  tvbs_in_if.sink               item_i,
  output logic                  push_o,
  output tvbs_pkg::tvbs_desc_t  desc_o,
  input  logic                  push_ready_i
);

  logic                 fmt_ok;
  logic [31:0]          hi_w;
  logic [31:0]          lo_w;
  tvbs_pkg::tvbs_c32_t  hi_c;
  tvbs_pkg::tvbs_c32_t  lo_c;

  assign hi_w = item_i.value[63:32];
  assign lo_w = item_i.value[31:0];
  assign hi_c = tvbs_pkg::comp32(hi_w);
  assign lo_c = tvbs_pkg::comp32(lo_w);

  always_comb begin
    fmt_ok       = 1'b1;
    desc_o.bytes = '0;
    desc_o.count = tvbs_pkg::CountW'(1);
    case (tvbs_pkg::tvbs_fmt_e'(item_i.format))
      tvbs_pkg::FmtByte: begin
        desc_o.bytes[0] = lo_w[7:0];
      end
      tvbs_pkg::FmtFixed32: begin
        desc_o.bytes[3:0] = tvbs_pkg::fixed32(lo_w);
        desc_o.count      = tvbs_pkg::CountW'(4);
      end
      tvbs_pkg::FmtFixed64: begin
        desc_o.bytes[3:0] = tvbs_pkg::fixed32(hi_w);
        desc_o.bytes[7:4] = tvbs_pkg::fixed32(lo_w);
        desc_o.count      = tvbs_pkg::CountW'(8);
      end
      tvbs_pkg::FmtComp32: begin
        desc_o.bytes[4:0] = lo_c.b;
        desc_o.count      = {1'b0, lo_c.n};
      end
      tvbs_pkg::FmtComp64: begin
        // low half lands right behind the high half
        desc_o.bytes[4:0] = hi_c.b;
        case (hi_c.n)
          3'd1:    desc_o.bytes[5:1] = lo_c.b;
          3'd2:    desc_o.bytes[6:2] = lo_c.b;
          3'd3:    desc_o.bytes[7:3] = lo_c.b;
          3'd4:    desc_o.bytes[8:4] = lo_c.b;
          default: desc_o.bytes[9:5] = lo_c.b;
        endcase
        desc_o.count = {1'b0, hi_c.n} + {1'b0, lo_c.n};
      end
      default: begin
        // unused codes: take the transfer, emit nothing
        fmt_ok = 1'b0;
      end
    endcase
  end

  assign item_i.ready = push_ready_i;
  assign push_o       = item_i.valid && fmt_ok;

endmodule

// ===== rtl/tvbs_queue.sv =====
// ----------------------------------------------------------------------------
// tvbs_queue
// Small descriptor FIFO between the front and back parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tvbs_queue #(
  parameter int unsigned Depth = tvbs_pkg::QueueDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  tvbs_pkg::tvbs_desc_t  push_desc_i,
  output logic                  ready_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output tvbs_pkg::tvbs_desc_t  desc_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  tvbs_pkg::tvbs_desc_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign ready_o = (cnt_q != Full);
  assign valid_o = (cnt_q != '0);
  assign desc_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_desc_i;
    end
  end

endmodule

// ===== rtl/tvbs_back.sv =====
// ----------------------------------------------------------------------------
// tvbs_back
// Shifts out the bytes of one descriptor per item into the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tvbs_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  input  tvbs_pkg::tvbs_desc_t  q_desc_i,
  output logic                  q_pop_o,
  tvbs_out_if.source            byte_o
);

  localparam int unsigned NB = tvbs_pkg::MaxBytes;
  localparam int unsigned BW = tvbs_pkg::ByteW;
  localparam int unsigned CW = tvbs_pkg::CountW;

  logic [NB-1:0][BW-1:0] bytes_q, bytes_d;
  logic [CW-1:0]         remain_q, remain_d;
  logic                  cur_valid_q, cur_valid_d;
  logic                  out_valid_q, out_valid_d;
  logic [BW-1:0]         out_byte_q, out_byte_d;
  logic                  out_last_q, out_last_d;
  logic                  adv;
  logic                  is_last;
  logic                  load;

  assign is_last = (remain_q == CW'(1));
  assign adv     = cur_valid_q && (!out_valid_q || byte_o.ready);
  assign load    = q_valid_i && (!cur_valid_q || (adv && is_last));
  assign q_pop_o = load;

  always_comb begin
    bytes_d     = bytes_q;
    remain_d    = remain_q;
    cur_valid_d = cur_valid_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    if (adv) begin
      out_valid_d = 1'b1;
      out_byte_d  = bytes_q[0];
      out_last_d  = is_last;
    end else if (byte_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      bytes_d     = q_desc_i.bytes;
      remain_d    = q_desc_i.count;
      cur_valid_d = 1'b1;
    end else if (adv) begin
      // advance to the next byte
      bytes_d     = {{BW{1'b0}}, bytes_q[NB-1:1]};
      remain_d    = remain_q - CW'(1);
      cur_valid_d = !is_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      remain_q    <= '0;
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      remain_q    <= remain_d;
      cur_valid_q <= cur_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bytes_q    <= bytes_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  assign byte_o.valid    = out_valid_q;
  assign byte_o.out_byte = out_byte_q;
  assign byte_o.last     = out_last_q;

  `TVBS_ASSERT(a_remain_range, cur_valid_q |-> (remain_q != '0 && remain_q <= CW'(NB)))
  `TVBS_ASSERT(a_last_marked, (adv && is_last) |=> (out_valid_q && out_last_q))
  `TVBS_ASSERT(a_mid_unmarked, (adv && !is_last) |=> (out_valid_q && !out_last_q))

endmodule

// ===== rtl/typed_value_byte_serializer_unit.sv =====
// ----------------------------------------------------------------------------
// typed_value_byte_serializer_unit
// Serializes one typed value per input transfer into a stream of bytes.
// ----------------------------------------------------------------------------
// Usage:
//   item_i  : input channel, one transfer per value (format code and 64-bit
//             raw value). Codes 5..7 are taken and produce no bytes.
//   byte_o  : output channel, one byte per transfer, most significant first;
//             last is high on the final byte of each value.
//   Path    : an input transfer writes its descriptor into the queue; the back
//             part loads it and registers its first byte in the output register.
//   Rate    : one output byte per cycle while byte_o is ready; a value has 1
//             to 10 bytes. Bytes of consecutive values follow with no gap once
//             the next value is queued.
//   Stall   : when byte_o is held, the output register keeps its byte, the
//             back part stops shifting and the descriptor queue fills; item_i
//             drops ready once the queue is full.
//   Reset   : rst_ni low empties the queue and the output register at once;
//             no clearing pass follows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module typed_value_byte_serializer_unit #(
  parameter int unsigned QueueDepth = tvbs_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tvbs_in_if.sink     item_i,
  tvbs_out_if.source  byte_o
);

  logic                 push;
  logic                 push_ready;
  tvbs_pkg::tvbs_desc_t push_desc;
  logic                 q_valid;
  logic                 q_pop;
  tvbs_pkg::tvbs_desc_t q_desc;

  tvbs_front u_front (
    .item_i       (item_i),
    .push_o       (push),
    .desc_o       (push_desc),
    .push_ready_i (push_ready)
  );

  tvbs_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_desc_i (push_desc),
    .ready_o     (push_ready),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .desc_o      (q_desc)
  );

  tvbs_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_desc_i  (q_desc),
    .q_pop_o   (q_pop),
    .byte_o    (byte_o)
  );

endmodule

// ===== verif/typed_value_byte_serializer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// typed_value_byte_serializer_unit_tb
// Drives typed values into the serializer and checks every output byte and its
// last flag against an independent encoder. A short table of directed values
// (format extremes, compact width boundaries, reserved codes) comes first.
// Random values follow, biased toward compact tier edges, under three pacing
// modes: slow receiver, slow sender, and full rate with one long output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module typed_value_byte_serializer_unit_tb;

  localparam int ClkPeriod   = 8;
  localparam int ResetCycles = 3;
  localparam int RandItems   = 385;
  localparam int HoldCycles  = 64;
  localparam int DrainCycles = 16;
  localparam int QuietLimit  = 2000;
  localparam int NumRows     = 25;

  // codes outside the enum; the block takes them and sends nothing
  localparam logic [2:0] FmtRsvdFirst = 3'd5;
  localparam logic [2:0] FmtRsvdMid   = 3'd6;
  localparam logic [2:0] FmtRsvdLast  = 3'd7;

  // compact tier ranges and tag bytes
  localparam int Tier1Min = -64;
  localparam int Tier1Max = 127;
  localparam int Tier2Min = -32'sh400;
  localparam int Tier2Max = 32'sh3ff;
  localparam int Tier3Min = -32'sh40000;
  localparam int Tier3Max = 32'sh3ffff;
  localparam int Tier4Min = -32'sh4000000;
  localparam int Tier4Max = 32'sh3ffffff;
  localparam logic [7:0] Tag2 = 8'h80;
  localparam logic [7:0] Tag3 = 8'h90;
  localparam logic [7:0] Tag4 = 8'ha0;
  localparam logic [7:0] Tag5 = 8'hb0;

  typedef enum logic [1:0] {
    PaceRxSlow,
    PaceTxSlow,
    PaceFull
  } pace_e;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  typedef struct packed {
    logic [2:0]  fmt;
    logic [63:0] value;
    logic        typed_exp;  // bytes below are the expected stream
    logic [3:0]  nb;
    logic [79:0] bytes;      // right justified, first byte highest
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tvbs_in_if  item_ch ();
  tvbs_out_if byte_ch ();

  typed_value_byte_serializer_unit DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_ch),
    .byte_o (byte_ch)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  pace_e      pace = PaceRxSlow;
  out_beat_t  expected_stream [$];
  logic [7:0] item_bytes [$];
  dir_row_t   dir_rows [NumRows];
  int         err_count     = 0;
  int         items_taken   = 0;
  int         rsvd_taken    = 0;
  int         bytes_checked = 0;
  int         longest_item  = 0;
  int         tier_hits [1:5] = '{0, 0, 0, 0, 0};

  task automatic report_mismatch(input string msg);
    $display("%0t ns: MISMATCH %s", $realtime, msg);
    err_count++;
  endtask

  // --------------------------------------------------------------------------
  // Encoder
  // --------------------------------------------------------------------------
  function automatic void put_word(input logic [31:0] w);
    item_bytes.push_back(w[31:24]);
    item_bytes.push_back(w[23:16]);
    item_bytes.push_back(w[15:8]);
    item_bytes.push_back(w[7:0]);
  endfunction

  function automatic void put_compact(input logic [31:0] u);
    int s;
    s = signed'(u);
    if (s >= Tier1Min && s <= Tier1Max) begin
      tier_hits[1]++;
      item_bytes.push_back(u[7:0]);
    end else if (s >= Tier2Min && s <= Tier2Max) begin
      tier_hits[2]++;
      item_bytes.push_back(Tag2 | {4'h0, u[11:8]});
      item_bytes.push_back(u[7:0]);
    end else if (s >= Tier3Min && s <= Tier3Max) begin
      tier_hits[3]++;
      item_bytes.push_back(Tag3 | {4'h0, u[19:16]});
      item_bytes.push_back(u[15:8]);
      item_bytes.push_back(u[7:0]);
    end else if (s >= Tier4Min && s <= Tier4Max) begin
      tier_hits[4]++;
      item_bytes.push_back(Tag4 | {4'h0, u[27:24]});
      item_bytes.push_back(u[23:16]);
      item_bytes.push_back(u[15:8]);
      item_bytes.push_back(u[7:0]);
    end else begin
      tier_hits[5]++;
      item_bytes.push_back(Tag5);
      put_word(u);
    end
  endfunction

  function automatic void serialize_value(input logic [2:0] fmt, input logic [63:0] value);
    item_bytes.delete();
    case (fmt)
      tvbs_pkg::FmtByte:    item_bytes.push_back(value[7:0]);
      tvbs_pkg::FmtFixed32: put_word(value[31:0]);
      tvbs_pkg::FmtFixed64: begin
        put_word(value[63:32]);
        put_word(value[31:0]);
      end
      tvbs_pkg::FmtComp32:  put_compact(value[31:0]);
      tvbs_pkg::FmtComp64: begin
        put_compact(value[63:32]);
        put_compact(value[31:0]);
      end
      default: ;
    endcase
  endfunction

  function automatic void commit_expected();
    out_beat_t beat;
    foreach (item_bytes[i]) begin
      beat.data = item_bytes[i];
      beat.last = (i == item_bytes.size() - 1);
      expected_stream.push_back(beat);
    end
    if (item_bytes.size() > longest_item) longest_item = item_bytes.size();
  endfunction

  // Half word: random, near a compact tier edge, sign extended from a random bit, or all zeros or ones
  function automatic logic [31:0] rand_half();
    logic [31:0]        w;
    logic signed [31:0] s;
    int                 k;
    int                 edge_val;
    case ($urandom_range(0, 3))
      0: w = $urandom;
      1: begin
        case ($urandom_range(0, 7))
          0: edge_val = Tier1Min;
          1: edge_val = Tier1Max;
          2: edge_val = Tier2Min;
          3: edge_val = Tier2Max;
          4: edge_val = Tier3Min;
          5: edge_val = Tier3Max;
          6: edge_val = Tier4Min;
          default: edge_val = Tier4Max;
        endcase
        w = edge_val + $urandom_range(0, 4) - 2;
      end
      2: begin
        // sign extend from a random bit
        k = $urandom_range(1, 31);
        s = $urandom;
        s = s << (31 - k);
        s = s >>> (31 - k);
        w = s;
      end
      default: w = $urandom_range(0, 1) ? 32'h0 : 32'hffff_ffff;
    endcase
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Item source
  // --------------------------------------------------------------------------
  task automatic offer_item(input logic [2:0] fmt, input logic [63:0] value);
    int idle_pct;
    idle_pct = (pace == PaceRxSlow) ? 34 : (pace == PaceTxSlow) ? 84 : 0;
    while ($urandom_range(0, 99) < idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_ch.valid  <= 1'b1;
    item_ch.format <= fmt;
    item_ch.value  <= value;
    do @(posedge clk_i); while (!item_ch.ready);
    items_taken++;
    if (fmt > tvbs_pkg::FmtComp64) rsvd_taken++;
  endtask

  initial begin : stimulus
    dir_row_t    row;
    logic [2:0]  fmt;
    logic [63:0] value;
    int          rand_sent;

    rst_ni         = 1'b0;
    item_ch.valid  = 1'b0;
    item_ch.format = '0;
    item_ch.value  = '0;

    dir_rows[0]  = '{tvbs_pkg::FmtByte,    64'h0,                   1'b1, 4'd1, 80'h00};
    dir_rows[1]  = '{tvbs_pkg::FmtByte,    64'hffff_ffff_ffff_ffff, 1'b1, 4'd1, 80'hff};
    dir_rows[2]  = '{tvbs_pkg::FmtByte,    64'h1,                   1'b1, 4'd1, 80'h01};
    dir_rows[3]  = '{tvbs_pkg::FmtFixed32, 64'hdead_beef_1234_5678, 1'b1, 4'd4, 80'h12345678};
    dir_rows[4]  = '{tvbs_pkg::FmtFixed64, 64'h0123_4567_89ab_cdef, 1'b1, 4'd8,
                     80'h0123456789abcdef};
    dir_rows[5]  = '{tvbs_pkg::FmtFixed64, 64'hffff_ffff_ffff_ffff, 1'b1, 4'd8,
                     80'hffffffffffffffff};
    dir_rows[6]  = '{tvbs_pkg::FmtComp32,  64'hffff_ffff_0000_007f, 1'b1, 4'd1, 80'h7f};
    dir_rows[7]  = '{tvbs_pkg::FmtComp32,  64'h0000_0000_ffff_ffc0, 1'b1, 4'd1, 80'hc0};
    dir_rows[8]  = '{tvbs_pkg::FmtComp32,  64'h0000_0000_0000_0080, 1'b0, 4'd0, 80'h0};
    dir_rows[9]  = '{tvbs_pkg::FmtComp32,  64'h0000_0000_ffff_ffbf, 1'b0, 4'd0, 80'h0};
    dir_rows[10] = '{tvbs_pkg::FmtComp32,  64'h0000_0000_0000_03ff, 1'b0, 4'd0, 80'h0};
    dir_rows[11] = '{tvbs_pkg::FmtComp32,  64'h0000_0000_ffff_fc00, 1'b0, 4'd0, 80'h0};
    dir_rows[12] = '{tvbs_pkg::FmtComp32,  64'h0000_0000_0003_ffff, 1'b0, 4'd0, 80'h0};
    dir_rows[13] = '{tvbs_pkg::FmtComp32,  64'h0000_0000_fffc_0000, 1'b0, 4'd0, 80'h0};
    dir_rows[14] = '{tvbs_pkg::FmtComp32,  64'h0000_0000_0004_0000, 1'b0, 4'd0, 80'h0};
    dir_rows[15] = '{tvbs_pkg::FmtComp32,  64'h0000_0000_03ff_ffff, 1'b0, 4'd0, 80'h0};
    dir_rows[16] = '{tvbs_pkg::FmtComp32,  64'h0000_0000_fc00_0000, 1'b0, 4'd0, 80'h0};
    dir_rows[17] = '{tvbs_pkg::FmtComp32,  64'h0000_0000_0400_0000, 1'b0, 4'd0, 80'h0};
    dir_rows[18] = '{tvbs_pkg::FmtComp32,  64'h0000_0000_7fff_ffff, 1'b1, 4'd5, 80'hb07fffffff};
    dir_rows[19] = '{tvbs_pkg::FmtComp32,  64'h0000_0000_8000_0000, 1'b1, 4'd5, 80'hb080000000};
    dir_rows[20] = '{tvbs_pkg::FmtComp64,  64'h0,                   1'b1, 4'd2, 80'h0000};
    dir_rows[21] = '{tvbs_pkg::FmtComp64,  64'h8000_0000_7fff_ffff, 1'b0, 4'd0, 80'h0};
    dir_rows[22] = '{FmtRsvdFirst,         64'h0123_4567_89ab_cdef, 1'b1, 4'd0, 80'h0};
    dir_rows[23] = '{FmtRsvdMid,           64'h0,                   1'b1, 4'd0, 80'h0};
    dir_rows[24] = '{FmtRsvdLast,          64'hffff_ffff_ffff_ffff, 1'b1, 4'd0, 80'h0};

    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumRows; r++) begin
      row = dir_rows[r];
      offer_item(row.fmt, row.value);
      if (row.typed_exp) begin
        item_bytes.delete();
        for (int b = row.nb - 1; b >= 0; b--) item_bytes.push_back(row.bytes[8*b +: 8]);
      end else begin
        serialize_value(row.fmt, row.value);
      end
      commit_expected();
    end

    rand_sent = 0;
    while (rand_sent < RandItems) begin
      pace = (rand_sent < RandItems / 3) ? PaceRxSlow :
             (rand_sent < 2 * RandItems / 3) ? PaceTxSlow : PaceFull;
      value[63:32] = $urandom;
      value[31:0]  = $urandom;
      case ($urandom_range(0, 9))
        0: fmt = tvbs_pkg::FmtByte;
        1: fmt = tvbs_pkg::FmtFixed32;
        2: fmt = tvbs_pkg::FmtFixed64;
        3, 4, 5: begin
          fmt         = tvbs_pkg::FmtComp32;
          value[31:0] = rand_half();
        end
        6, 7, 8: begin
          fmt = tvbs_pkg::FmtComp64;
          value[63:32] = rand_half();
          value[31:0]  = rand_half();
        end
        default: fmt = 3'($urandom_range(FmtRsvdFirst, FmtRsvdLast));
      endcase
      offer_item(fmt, value);
      serialize_value(fmt, value);
      commit_expected();
      rand_sent++;
    end
    item_ch.valid <= 1'b0;

    while (expected_stream.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d items (%0d with reserved codes), %0d bytes checked, longest %0d",
             items_taken, rsvd_taken, bytes_checked, longest_item);
    $display("compact widths 1..5 hit %0d/%0d/%0d/%0d/%0d times",
             tier_hits[1], tier_hits[2], tier_hits[3], tier_hits[4], tier_hits[5]);
    if (err_count == 0) begin
      $display("typed_value_byte_serializer_unit_tb: clean");
    end else begin
      $display("typed_value_byte_serializer_unit_tb: errors");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Byte sink: random ready, one long hold when full rate starts
  // --------------------------------------------------------------------------
  initial begin : byte_sink
    bit held;
    int hold_left;
    int idle_pct;
    held          = 1'b0;
    hold_left     = 0;
    byte_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (pace == PaceFull && !held) begin
        held      = 1'b1;
        hold_left = HoldCycles;
      end
      idle_pct = (pace == PaceRxSlow) ? 84 : (pace == PaceTxSlow) ? 34 : 0;
      if (hold_left > 0) begin
        hold_left--;
        byte_ch.ready <= 1'b0;
      end else begin
        byte_ch.ready <= ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin : byte_check
    out_beat_t want;
    if (rst_ni && byte_ch.valid && byte_ch.ready) begin
      bytes_checked++;
      if (expected_stream.size() == 0) begin
        report_mismatch($sformatf("byte %02h last %0b with nothing expected",
                                  byte_ch.out_byte, byte_ch.last));
      end else begin
        want = expected_stream.pop_front();
        if (byte_ch.out_byte !== want.data)
          report_mismatch($sformatf("out_byte got %02h expected %02h",
                                    byte_ch.out_byte, want.data));
        if (byte_ch.last !== want.last)
          report_mismatch($sformatf("last got %0b expected %0b on byte %02h",
                                    byte_ch.last, want.last, want.data));
      end
    end
  end

  // End the run if no transfer happens on either channel for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((item_ch.valid && item_ch.ready) || (byte_ch.valid && byte_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: %0d cycles without a transfer, %0d bytes still expected",
             quiet, expected_stream.size());
    $display("typed_value_byte_serializer_unit_tb: errors");
    $finish;
  end

endmodule
